@@ sv/srdcc_pkg.sv @@
// Shared types and constants of the sparse row distinct column counter.
`default_nettype none

package srdcc_pkg;

    // Field widths of the stream and configuration ports
    localparam int COLUMN_KEY_W = 24;
    localparam int IN_TDATA_W   = 24;
    localparam int COUNT_W      = 20;
    localparam int OUT_TDATA_W  = 24;
    localparam int SIZE_W       = 13;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Row tag stored beside each key; a slot is occupied only if its tag matches
    localparam int EPOCH_W = 8;

    // Defaults for the top-level parameters
    localparam int PRIMARY_DEPTH_DEF   = 512;
    localparam int SECONDARY_DEPTH_DEF = 4096;
    localparam int KEY_BITS_DEF        = 24;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_PROBE,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               failed;
    } t_row_result;

endpackage

`default_nettype wire

@@ sv/sparse_row_distinct_column_counter.sv @@
// Top level of the sparse row distinct column counter.
//
// Counts the distinct column keys of one sparse product row. Each input
// transfer carries a column key in tdata, tuser high when the key is present,
// and tlast to close the row. Keys go into a primary linear-probing hash set
// in a PRIMARY_DEPTH-entry RAM and, once that is full, into a secondary set of
// secondary_size slots (at most SECONDARY_DEPTH), written through i_cfg_we /
// i_cfg_wdata while idle; the user, not the block, must ensure this. A key
// is taken in idle and passes the look state while its first slot is read;
// the probe loop then reads one RAM slot per cycle. A key that spills into
// the secondary set passes look again and probes there. A row end yields one
// output transfer: the count in tdata and the failed flag in tuser. Sets are
// emptied by a row tag kept with each key, so no per-row clearing is needed;
// after reset and every 255 rows a clearing pass over max(PRIMARY_DEPTH,
// SECONDARY_DEPTH) slots runs with o_s_axis_tready low. A finished result is
// held in an output register, so the next row is taken while it waits.
`default_nettype none

module sparse_row_distinct_column_counter #(
    parameter int PRIMARY_DEPTH   = srdcc_pkg::PRIMARY_DEPTH_DEF,
    parameter int SECONDARY_DEPTH = srdcc_pkg::SECONDARY_DEPTH_DEF,
    parameter int KEY_BITS        = srdcc_pkg::KEY_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [srdcc_pkg::SIZE_W-1:0]       i_cfg_wdata,
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    input  wire logic [srdcc_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,  // column_key
    input  wire logic                               i_s_axis_tuser,  // key_valid
    input  wire logic                               i_s_axis_tlast,  // row_end
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    output logic      [srdcc_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,  // row_count, zero pad
    output logic                                    o_m_axis_tuser   // row_failed
);

    logic [srdcc_pkg::SIZE_W-1:0]  r_sec_size;
    logic                          r_out_valid;
    srdcc_pkg::t_row_result        r_out;
    logic [KEY_BITS-1:0]           w_key;
    logic                          w_res_valid;
    srdcc_pkg::t_row_result        w_res;
    logic                          w_res_ready;

    assign w_key       = KEY_BITS'(i_s_axis_tdata[srdcc_pkg::COLUMN_KEY_W-1:0]);
    assign w_res_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec_size <= '0;
        end else if (i_cfg_we) begin
            r_sec_size <= i_cfg_wdata;
        end
    end

    // Hold the result until the downstream transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    srdcc_probe #(
        .PRIMARY_DEPTH   (PRIMARY_DEPTH),
        .SECONDARY_DEPTH (SECONDARY_DEPTH),
        .KEY_BITS        (KEY_BITS)
    ) u_probe (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_item_valid     (i_s_axis_tvalid),
        .o_item_ready     (o_s_axis_tready),
        .i_item_key       (w_key),
        .i_item_has_key   (i_s_axis_tuser),
        .i_item_end       (i_s_axis_tlast),
        .i_secondary_size (r_sec_size),
        .o_res_valid      (w_res_valid),
        .o_res            (w_res),
        .i_res_ready      (w_res_ready)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = srdcc_pkg::OUT_TDATA_W'(r_out.count);
    assign o_m_axis_tuser  = r_out.failed;

endmodule

`default_nettype wire

@@ sv/srdcc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module srdcc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ sv/srdcc_probe.sv @@
// Linear-probing hash engine over the primary and secondary key memories.
`default_nettype none

module srdcc_probe #(
    parameter int PRIMARY_DEPTH   = srdcc_pkg::PRIMARY_DEPTH_DEF,
    parameter int SECONDARY_DEPTH = srdcc_pkg::SECONDARY_DEPTH_DEF,
    parameter int KEY_BITS        = srdcc_pkg::KEY_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_item_valid,
    output logic                               o_item_ready,
    input  wire logic [KEY_BITS-1:0]           i_item_key,
    input  wire logic                          i_item_has_key,
    input  wire logic                          i_item_end,
    input  wire logic [srdcc_pkg::SIZE_W-1:0]  i_secondary_size,
    output logic                               o_res_valid,
    output srdcc_pkg::t_row_result             o_res,
    input  wire logic                          i_res_ready
);

    localparam int PA_W    = (PRIMARY_DEPTH > 1) ? $clog2(PRIMARY_DEPTH) : 1;
    localparam int SEC_MEM = (SECONDARY_DEPTH > 0) ? SECONDARY_DEPTH : 1;
    localparam int SA_W    = (SEC_MEM > 1) ? $clog2(SEC_MEM) : 1;
    localparam int AW      = (PA_W > SA_W) ? PA_W : SA_W;
    localparam int SW      = AW + 1;
    localparam int SWEEP_N = (PRIMARY_DEPTH > SEC_MEM) ? PRIMARY_DEPTH : SEC_MEM;
    localparam int WORD_W  = srdcc_pkg::EPOCH_W + KEY_BITS;
    localparam int EW      = srdcc_pkg::EPOCH_W;
    localparam int CW      = srdcc_pkg::COUNT_W;

    localparam logic [SW-1:0] P_SIZE     = SW'(PRIMARY_DEPTH);
    localparam logic [AW-1:0] P_MASK     = AW'(PRIMARY_DEPTH - 1);
    localparam logic [AW-1:0] SWEEP_LAST = AW'(SWEEP_N - 1);
    localparam logic [EW-1:0] EPOCH_LAST = {EW{1'b1}};
    localparam logic [EW-1:0] EPOCH_ONE  = EW'(1);

    srdcc_pkg::t_state r_state, n_state;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic                r_end, n_end;
    logic                r_sec, n_sec;
    logic [AW-1:0]       r_slot, n_slot;
    logic [SW-1:0]       r_probe, n_probe;
    logic [CW-1:0]       r_count, n_count;
    logic                r_failed, n_failed;
    logic [EW-1:0]       r_epoch, n_epoch;
    logic [AW-1:0]       r_sweep, n_sweep;

    logic [SW-1:0]     w_ssize;
    logic [AW-1:0]     w_smask;
    logic [SW-1:0]     w_size;
    logic [SW-1:0]     w_mask_full;
    logic [AW-1:0]     w_mask;
    logic [AW-1:0]     w_next;
    logic [SW-1:0]     w_probe_next;
    logic [CW-1:0]     w_count_inc;
    logic [WORD_W-1:0] w_pri_rdata;
    logic [WORD_W-1:0] w_sec_rdata;
    logic [WORD_W-1:0] w_rdata;
    logic              w_occupied;
    logic              w_match;
    logic [AW-1:0]     w_raddr;
    logic              w_ins_we;
    logic              w_pri_we;
    logic              w_sec_we;
    logic [AW-1:0]     w_waddr;
    logic [WORD_W-1:0] w_wdata;

    // Secondary size in use, held to the memory depth
    always_comb begin
        if (32'(i_secondary_size) > 32'(SECONDARY_DEPTH)) begin
            w_ssize = SW'(SECONDARY_DEPTH);
        end else begin
            w_ssize = SW'(i_secondary_size);
        end
    end

    assign w_smask      = AW'(w_ssize - SW'(1));
    assign w_size       = r_sec ? w_ssize : P_SIZE;
    assign w_mask_full  = w_size - SW'(1);
    assign w_mask       = w_mask_full[AW-1:0];
    assign w_next       = (r_slot + AW'(1)) & w_mask;
    assign w_probe_next = r_probe + SW'(1);
    assign w_count_inc  = (r_count == srdcc_pkg::COUNT_MAX) ? r_count : r_count + CW'(1);

    assign w_rdata    = r_sec ? w_sec_rdata : w_pri_rdata;
    assign w_occupied = (w_rdata[WORD_W-1 -: EW] == r_epoch);
    assign w_match    = (w_rdata[KEY_BITS-1:0] == r_key);

    // Read the slot under test, or run one slot ahead while probing
    assign w_raddr = (r_state == srdcc_pkg::ST_PROBE) ? w_next : r_slot;

    assign w_ins_we = (r_state == srdcc_pkg::ST_PROBE) && !w_occupied;
    assign w_waddr  = (r_state == srdcc_pkg::ST_CLEAR) ? r_sweep : r_slot;
    assign w_wdata  = (r_state == srdcc_pkg::ST_CLEAR) ? '0 : {r_epoch, r_key};
    assign w_pri_we = ((r_state == srdcc_pkg::ST_CLEAR) && (32'(r_sweep) < 32'(PRIMARY_DEPTH)))
                   || (w_ins_we && !r_sec);
    assign w_sec_we = ((r_state == srdcc_pkg::ST_CLEAR) && (32'(r_sweep) < 32'(SEC_MEM)))
                   || (w_ins_we && r_sec);

    srdcc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (PRIMARY_DEPTH)
    ) u_pri_ram (
        .i_clk   (i_clk),
        .i_we    (w_pri_we),
        .i_waddr (w_waddr[PA_W-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr[PA_W-1:0]),
        .o_rdata (w_pri_rdata)
    );

    srdcc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SEC_MEM)
    ) u_sec_ram (
        .i_clk   (i_clk),
        .i_we    (w_sec_we),
        .i_waddr (w_waddr[SA_W-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr[SA_W-1:0]),
        .o_rdata (w_sec_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= srdcc_pkg::ST_CLEAR;
            r_count  <= '0;
            r_failed <= 1'b0;
            r_epoch  <= EPOCH_ONE;
            r_sweep  <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_failed <= n_failed;
            r_epoch  <= n_epoch;
            r_sweep  <= n_sweep;
        end
        r_key   <= n_key;
        r_end   <= n_end;
        r_sec   <= n_sec;
        r_slot  <= n_slot;
        r_probe <= n_probe;
    end

    always_comb begin
        n_state      = r_state;
        n_key        = r_key;
        n_end        = r_end;
        n_sec        = r_sec;
        n_slot       = r_slot;
        n_probe      = r_probe;
        n_count      = r_count;
        n_failed     = r_failed;
        n_epoch      = r_epoch;
        n_sweep      = r_sweep;
        o_item_ready = 1'b0;
        o_res_valid  = 1'b0;
        o_res.count  = r_count;
        o_res.failed = r_failed;

        unique case (r_state)
            srdcc_pkg::ST_CLEAR: begin
                // Wipe every row tag, then restart the tags at one
                n_sweep = r_sweep + AW'(1);
                if (r_sweep == SWEEP_LAST) begin
                    n_epoch = EPOCH_ONE;
                    n_state = srdcc_pkg::ST_IDLE;
                end
            end
            srdcc_pkg::ST_IDLE: begin
                o_item_ready = 1'b1;
                if (i_item_valid) begin
                    n_key   = i_item_key;
                    n_end   = i_item_end;
                    n_sec   = 1'b0;
                    n_slot  = AW'(i_item_key) & P_MASK;
                    n_probe = '0;
                    if (i_item_has_key) begin
                        n_state = srdcc_pkg::ST_LOOK;
                    end else if (i_item_end) begin
                        n_state = srdcc_pkg::ST_FIN;
                    end
                end
            end
            srdcc_pkg::ST_LOOK: begin
                n_state = srdcc_pkg::ST_PROBE;
            end
            srdcc_pkg::ST_PROBE: begin
                priority if (!w_occupied) begin
                    n_count = w_count_inc;
                    n_state = r_end ? srdcc_pkg::ST_FIN : srdcc_pkg::ST_IDLE;
                end else if (w_match) begin
                    n_state = r_end ? srdcc_pkg::ST_FIN : srdcc_pkg::ST_IDLE;
                end else if (w_probe_next == w_size) begin
                    if (!r_sec && (w_ssize != '0)) begin
                        // Primary set full: start over in the overflow set
                        n_sec   = 1'b1;
                        n_slot  = AW'(r_key) & w_smask;
                        n_probe = '0;
                        n_state = srdcc_pkg::ST_LOOK;
                    end else begin
                        n_count  = w_count_inc;
                        n_failed = 1'b1;
                        n_state  = r_end ? srdcc_pkg::ST_FIN : srdcc_pkg::ST_IDLE;
                    end
                end else begin
                    n_slot  = w_next;
                    n_probe = w_probe_next;
                end
            end
            srdcc_pkg::ST_FIN: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_count  = '0;
                    n_failed = 1'b0;
                    // A new tag empties both sets; sweep once the tags run out
                    if (r_epoch == EPOCH_LAST) begin
                        n_sweep = '0;
                        n_state = srdcc_pkg::ST_CLEAR;
                    end else begin
                        n_epoch = r_epoch + EW'(1);
                        n_state = srdcc_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = srdcc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
